/* sv/pixel_color_matrix_projection_assert.svh */
// Assertion macros for the color matrix projection block.
`ifndef PIXEL_COLOR_MATRIX_PROJECTION_ASSERT_SVH
`define PIXEL_COLOR_MATRIX_PROJECTION_ASSERT_SVH

// Checked only outside reset.
`define PCMP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every edge, reset included.
`define PCMP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* sv/pcmp_pkg.sv */
package pcmp_pkg;

  localparam int NUM_CH          = 3;
  localparam int SAMPLE_W        = 20;
  localparam int COEF_W          = 21;
  localparam int CFG_W           = NUM_CH * COEF_W;
  localparam int PROD_W          = SAMPLE_W + COEF_W;
  localparam int SUM_W           = PROD_W + 2;
  localparam int OUT_W           = 32;
  localparam int CNT_W           = 32;
  localparam int POS_W           = 8;
  localparam int OFFSET_W        = 20;
  localparam int TILE_EDGE       = 256;
  localparam int BYTES_PER_PIXEL = 12;
  localparam int ROUND_SHIFT     = 10;
  localparam int ADD_W           = 2;

  localparam int S_TDATA_W = ((NUM_CH * SAMPLE_W + 2 * POS_W + 7) / 8) * 8;
  localparam int M_TDATA_W = ((NUM_CH * OUT_W + OFFSET_W + 2 * CNT_W + 7) / 8) * 8;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [COEF_W-1:0]   coef_t;
  typedef logic        [CFG_W-1:0]    coef_row_t;
  typedef coef_row_t   [NUM_CH-1:0]   coef_mat_t;
  typedef logic signed [PROD_W-1:0]   prod_t;
  typedef logic signed [SUM_W-1:0]    sum_t;
  typedef logic signed [OUT_W-1:0]    comp_t;
  typedef logic        [OFFSET_W-1:0] offset_t;
  typedef logic        [CNT_W-1:0]    count_t;
  typedef logic        [POS_W-1:0]    pos_t;

  // Identity matrix in Q8.12: 1.0 on the diagonal.
  localparam coef_row_t ROW_ONE_RESET   = CFG_W'(64'd4096);
  localparam coef_row_t ROW_TWO_RESET   = CFG_W'(64'd8589934592);
  localparam coef_row_t ROW_THREE_RESET = CFG_W'(64'd18014398509481984);

  localparam sum_t  ROUND_HALF = SUM_W'(1 << (ROUND_SHIFT - 1));
  localparam sum_t  SAT_MAX    = SUM_W'(2147483647);
  localparam sum_t  SAT_MIN    = -SUM_W'(64'sd2147483648);
  localparam comp_t COMP_MAX   = OUT_W'(32'h7fff_ffff);
  localparam comp_t COMP_MIN   = OUT_W'(32'h8000_0000);
  localparam comp_t Q19_ONE    = OUT_W'(524288);
  localparam count_t COUNT_MAX = '1;

  typedef enum logic [1:0] {
    REG_ROW_ONE   = 2'd0,
    REG_ROW_TWO   = 2'd1,
    REG_ROW_THREE = 2'd2
  } reg_index_t;

  typedef struct packed {
    sample_t cam_red;
    sample_t cam_green;
    sample_t cam_blue;
    pos_t    pixel_col;
    pos_t    pixel_row;
    logic    first_of_image;
  } pixel_t;

  typedef struct packed {
    prod_t [NUM_CH-1:0][NUM_CH-1:0] prod;
    offset_t tile_byte_offset;
    logic    first_of_image;
  } prod_stage_t;

  typedef struct packed {
    comp_t   xyz_x;
    comp_t   xyz_y;
    comp_t   xyz_z;
    offset_t tile_byte_offset;
    count_t  negative_count;
    count_t  over_one_count;
    logic    overflow_flag;
  } result_t;

endpackage

/* sv/pcmp_mult.sv */
module pcmp_mult import pcmp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  pixel_t      pix,
  input  coef_mat_t   coefs,
  output logic        out_valid,
  input  logic        out_ready,
  output prod_stage_t prods
);

  prod_stage_t prods_next;
  sample_t     samp [NUM_CH];
  logic [OFFSET_W-1:0] pix_index;

  assign in_ready = !out_valid || out_ready;

  assign samp[0] = pix.cam_red;
  assign samp[1] = pix.cam_green;
  assign samp[2] = pix.cam_blue;

  // Position wraps to the offset width, as the offset itself does.
  assign pix_index = OFFSET_W'(pix.pixel_row) * OFFSET_W'(TILE_EDGE)
                   + OFFSET_W'(pix.pixel_col);

  always_comb begin
    coef_t c;
    c = '0;
    for (int r = 0; r < NUM_CH; r++) begin
      for (int k = 0; k < NUM_CH; k++) begin
        c = coef_t'(coefs[r][k*COEF_W +: COEF_W]);
        prods_next.prod[r][k] = prod_t'(c) * prod_t'(samp[k]);
      end
    end
    prods_next.tile_byte_offset = pix_index * OFFSET_W'(BYTES_PER_PIXEL);
    prods_next.first_of_image   = pix.first_of_image;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      prods <= prods_next;
    end
  end

endmodule

/* sv/pcmp_accum.sv */
module pcmp_accum import pcmp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  prod_stage_t prods,
  output logic        out_valid,
  input  logic        out_ready,
  output result_t     result
);

  count_t  neg_count;
  count_t  over_count;
  count_t  neg_count_next;
  count_t  over_count_next;
  comp_t   comp [NUM_CH];
  logic [NUM_CH-1:0] sat;
  logic [NUM_CH-1:0] is_neg;
  logic [NUM_CH-1:0] is_over;
  logic [ADD_W-1:0]  neg_add;
  logic [ADD_W-1:0]  over_add;
  logic              load;

  assign in_ready = !out_valid || out_ready;
  assign load     = in_valid && in_ready;

  always_comb begin
    sum_t s;
    sum_t rnd;
    s   = '0;
    rnd = '0;
    for (int r = 0; r < NUM_CH; r++) begin
      s = SUM_W'(prods.prod[r][0]) + SUM_W'(prods.prod[r][1]) + SUM_W'(prods.prod[r][2]);
      // Round to nearest, ties toward plus infinity.
      rnd = (s + ROUND_HALF) >>> ROUND_SHIFT;
      if (rnd > SAT_MAX) begin
        comp[r] = COMP_MAX;
        sat[r]  = 1'b1;
      end else if (rnd < SAT_MIN) begin
        comp[r] = COMP_MIN;
        sat[r]  = 1'b1;
      end else begin
        comp[r] = comp_t'(rnd);
        sat[r]  = 1'b0;
      end
      is_neg[r]  = comp[r] < 0;
      is_over[r] = comp[r] > Q19_ONE;
    end
  end

  assign neg_add  = ADD_W'(is_neg[0])  + ADD_W'(is_neg[1])  + ADD_W'(is_neg[2]);
  assign over_add = ADD_W'(is_over[0]) + ADD_W'(is_over[1]) + ADD_W'(is_over[2]);

  always_comb begin
    logic [CNT_W:0] neg_sum;
    logic [CNT_W:0] over_sum;
    count_t         neg_base;
    count_t         over_base;
    // Start of image: drop the old counts before counting this pixel.
    neg_base  = prods.first_of_image ? '0 : neg_count;
    over_base = prods.first_of_image ? '0 : over_count;
    neg_sum   = (CNT_W+1)'(neg_base)  + (CNT_W+1)'(neg_add);
    over_sum  = (CNT_W+1)'(over_base) + (CNT_W+1)'(over_add);
    neg_count_next  = neg_sum[CNT_W]  ? COUNT_MAX : neg_sum[CNT_W-1:0];
    over_count_next = over_sum[CNT_W] ? COUNT_MAX : over_sum[CNT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      neg_count  <= '0;
      over_count <= '0;
    end else begin
      if (in_ready) begin
        out_valid <= in_valid;
      end
      if (load) begin
        neg_count  <= neg_count_next;
        over_count <= over_count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result.xyz_x            <= comp[0];
      result.xyz_y            <= comp[1];
      result.xyz_z            <= comp[2];
      result.tile_byte_offset <= prods.tile_byte_offset;
      result.negative_count   <= neg_count_next;
      result.over_one_count   <= over_count_next;
      result.overflow_flag    <= |sat;
    end
  end

endmodule

/* sv/pixel_color_matrix_projection.sv */
// Each item passes the input, product and result registers in that order.
// Throughput: one item per clock unless a low m_tready stalls the output; the
// nine products are formed in parallel. Each stage holds one item and moves
// on when the stage after it is free.
// Reset (rst, synchronous): empties the pipeline, clears both counters and
// loads the identity matrix.
`include "pixel_color_matrix_projection_assert.svh"

module pixel_color_matrix_projection import pcmp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [1:0]           cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // cam_red, cam_green, cam_blue, pixel_col, pixel_row, zero pad
  input  logic [S_TDATA_W-1:0] s_tdata,
  // first_of_image
  input  logic                 s_tuser,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // xyz_x, xyz_y, xyz_z, tile_byte_offset, negative_count, over_one_count, zero pad
  output logic [M_TDATA_W-1:0] m_tdata,
  // overflow_flag
  output logic                 m_tuser
);

  coef_mat_t   coefs;
  logic        pix_valid;
  pixel_t      pix;
  pixel_t      pix_next;
  logic        mult_ready;
  logic        prod_valid;
  logic        acc_ready;
  prod_stage_t prods;
  result_t     result;

  always_ff @(posedge clk) begin
    if (rst) begin
      coefs[0] <= ROW_ONE_RESET;
      coefs[1] <= ROW_TWO_RESET;
      coefs[2] <= ROW_THREE_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_ROW_ONE:   coefs[0] <= cfg_data;
        REG_ROW_TWO:   coefs[1] <= cfg_data;
        REG_ROW_THREE: coefs[2] <= cfg_data;
        default:       ;
      endcase
    end
  end

  always_comb begin
    pix_next.cam_red        = sample_t'(s_tdata[0*SAMPLE_W +: SAMPLE_W]);
    pix_next.cam_green      = sample_t'(s_tdata[1*SAMPLE_W +: SAMPLE_W]);
    pix_next.cam_blue       = sample_t'(s_tdata[2*SAMPLE_W +: SAMPLE_W]);
    pix_next.pixel_col      = s_tdata[NUM_CH*SAMPLE_W +: POS_W];
    pix_next.pixel_row      = s_tdata[NUM_CH*SAMPLE_W + POS_W +: POS_W];
    pix_next.first_of_image = s_tuser;
  end

  assign s_tready = !pix_valid || mult_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pix_valid <= 1'b0;
    end else if (s_tready) begin
      pix_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      pix <= pix_next;
    end
  end

  pcmp_mult u_mult (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (pix_valid),
    .in_ready  (mult_ready),
    .pix       (pix),
    .coefs     (coefs),
    .out_valid (prod_valid),
    .out_ready (acc_ready),
    .prods     (prods)
  );

  pcmp_accum u_accum (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (prod_valid),
    .in_ready  (acc_ready),
    .prods     (prods),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .result    (result)
  );

  assign m_tdata = M_TDATA_W'({result.over_one_count, result.negative_count,
                               result.tile_byte_offset, result.xyz_z,
                               result.xyz_y, result.xyz_x});
  assign m_tuser = result.overflow_flag;

  `PCMP_ASSERT_ALWAYS(a_reset_empties, rst |=> !m_tvalid, "result valid right after reset")
  `PCMP_ASSERT(a_no_overflow, m_tvalid |-> !m_tuser, "component saturated")
  `PCMP_ASSERT(a_empty_accepts, !m_tvalid |-> s_tready, "pipeline blocked with empty output")

endmodule

/* dv/pixel_color_matrix_projection_tb.sv */
`timescale 1ns / 100ps

module pixel_color_matrix_projection_tb import pcmp_pkg::*;;

  localparam int LIMIT_CYCLES = 400000;
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_PHASES = 7;
  localparam int PHASE_ITEMS = 135;
  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int COEF_POS_MAX = 1048575;
  localparam int COEF_NEG_MAX = -1048576;
  localparam int SAMPLE_POS_MAX = 524287;
  localparam int SAMPLE_NEG_MAX = -524288;
  localparam int SAMPLE_ONE = 131072;

  // Tracks the matrix and both counters, and queues the XYZ results owed.
  class xyz_tracker;
    coef_row_t rows[NUM_CH];
    count_t neg_tally;
    count_t over_tally;
    result_t pending[$];
    int fails;

    function new();
      rows[0] = ROW_ONE_RESET;
      rows[1] = ROW_TWO_RESET;
      rows[2] = ROW_THREE_RESET;
      neg_tally = '0;
      over_tally = '0;
      fails = 0;
    endfunction

    function void set_row(logic [1:0] idx, coef_row_t val);
      case (idx)
        REG_ROW_ONE: rows[0] = val;
        REG_ROW_TWO: rows[1] = val;
        REG_ROW_THREE: rows[2] = val;
        default: ;
      endcase
    endfunction

    function int waiting();
      return pending.size();
    endfunction

    function void note_pixel(pixel_t p);
      longint samp[NUM_CH];
      longint acc;
      longint comp;
      coef_t k;
      comp_t xyz[NUM_CH];
      result_t r;
      r = '0;
      samp[0] = longint'(p.cam_red);
      samp[1] = longint'(p.cam_green);
      samp[2] = longint'(p.cam_blue);
      if (p.first_of_image) begin
        neg_tally = '0;
        over_tally = '0;
      end
      for (int i = 0; i < NUM_CH; i++) begin
        acc = 0;
        for (int c = 0; c < NUM_CH; c++) begin
          k = rows[i][c*COEF_W +: COEF_W];
          acc += longint'(k) * samp[c];
        end
        // round half up, drop 10 fraction bits
        comp = (acc + 512) >>> ROUND_SHIFT;
        if (comp > 64'sd2147483647) begin
          comp = 64'sd2147483647;
          r.overflow_flag = 1'b1;
        end
        if (comp < -64'sd2147483648) begin
          comp = -64'sd2147483648;
          r.overflow_flag = 1'b1;
        end
        xyz[i] = comp_t'(comp);
      end
      for (int i = 0; i < NUM_CH; i++) begin
        if (xyz[i] < 0 && neg_tally != COUNT_MAX) neg_tally++;
        if (xyz[i] > Q19_ONE && over_tally != COUNT_MAX) over_tally++;
      end
      r.xyz_x = xyz[0];
      r.xyz_y = xyz[1];
      r.xyz_z = xyz[2];
      r.tile_byte_offset =
        offset_t'((int'(p.pixel_row) * TILE_EDGE + int'(p.pixel_col)) * BYTES_PER_PIXEL);
      r.negative_count = neg_tally;
      r.over_one_count = over_tally;
      pending = {pending, r};
    endfunction

    function void compare(string name, longint want, longint got);
      if (want != got) begin
        fails++;
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      end
    endfunction

    function void check_xyz(result_t got);
      result_t want;
      if (pending.size() == 0) begin
        fails++;
        $display("%0t: unexpected result, nothing pending, got x=%0d y=%0d z=%0d",
                 $time, got.xyz_x, got.xyz_y, got.xyz_z);
        return;
      end
      want = pending.pop_front();
      compare("xyz_x", want.xyz_x, got.xyz_x);
      compare("xyz_y", want.xyz_y, got.xyz_y);
      compare("xyz_z", want.xyz_z, got.xyz_z);
      compare("tile_byte_offset", want.tile_byte_offset, got.tile_byte_offset);
      compare("negative_count", want.negative_count, got.negative_count);
      compare("over_one_count", want.over_one_count, got.over_one_count);
      compare("overflow_flag", want.overflow_flag, got.overflow_flag);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic [1:0] cfg_index = REG_ROW_ONE;
  logic [CFG_W-1:0] cfg_data = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;
  logic s_tuser = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;
  logic m_tuser;

  xyz_tracker board;

  pixel_color_matrix_projection uut (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin : watch_input
    pixel_t p;
    if (!rst && s_tvalid && s_tready) begin
      p.cam_red = s_tdata[0 +: SAMPLE_W];
      p.cam_green = s_tdata[SAMPLE_W +: SAMPLE_W];
      p.cam_blue = s_tdata[2*SAMPLE_W +: SAMPLE_W];
      p.pixel_col = s_tdata[3*SAMPLE_W +: POS_W];
      p.pixel_row = s_tdata[3*SAMPLE_W+POS_W +: POS_W];
      p.first_of_image = s_tuser;
      board.note_pixel(p);
    end
  end

  always @(posedge clk) begin : watch_output
    result_t r;
    if (!rst && m_tvalid && m_tready) begin
      r.xyz_x = m_tdata[0 +: OUT_W];
      r.xyz_y = m_tdata[OUT_W +: OUT_W];
      r.xyz_z = m_tdata[2*OUT_W +: OUT_W];
      r.tile_byte_offset = m_tdata[3*OUT_W +: OFFSET_W];
      r.negative_count = m_tdata[3*OUT_W+OFFSET_W +: CNT_W];
      r.over_one_count = m_tdata[3*OUT_W+OFFSET_W+CNT_W +: CNT_W];
      r.overflow_flag = m_tuser;
      board.check_xyz(r);
    end
  end

  initial begin : watchdog
    for (int cycles = 0; cycles < LIMIT_CYCLES; cycles++) @(posedge clk);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic coef_row_t pack_row(int c0, int c1, int c2);
    coef_t k0, k1, k2;
    k0 = coef_t'(c0);
    k1 = coef_t'(c1);
    k2 = coef_t'(c2);
    return {k2, k1, k0};
  endfunction

  function automatic pixel_t mk_pixel(int r, int g, int b, int col, int row, bit first);
    pixel_t p;
    p.cam_red = sample_t'(r);
    p.cam_green = sample_t'(g);
    p.cam_blue = sample_t'(b);
    p.pixel_col = pos_t'(col);
    p.pixel_row = pos_t'(row);
    p.first_of_image = first;
    return p;
  endfunction

  function automatic int random_sample();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return $urandom_range(0, 157286);
    if (r < 70) return int'(sample_t'($urandom));
    if (r < 85) return int'($urandom_range(0, 4000)) - 2000;
    case ($urandom_range(0, 3))
      0: return SAMPLE_NEG_MAX;
      1: return SAMPLE_POS_MAX;
      2: return SAMPLE_ONE;
      default: return 0;
    endcase
  endfunction

  // Rows either fully random or near a plausible camera matrix (about +-2.0).
  function automatic coef_row_t random_row(bit plausible);
    if (plausible)
      return pack_row(int'($urandom_range(0, 16383)) - 8192,
                      int'($urandom_range(0, 16383)) - 8192,
                      int'($urandom_range(0, 16383)) - 8192);
    return coef_row_t'({$urandom, $urandom});
  endfunction

  task automatic send_pixel(input pixel_t p);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= S_TDATA_W'({p.pixel_row, p.pixel_col, p.cam_blue, p.cam_green, p.cam_red});
    s_tuser <= p.first_of_image;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Lower valid, then hold until every owed result is back.
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (board.waiting() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_row(input logic [1:0] idx, input coef_row_t val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    board.set_row(idx, val);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic accept_results();
    int gap;
    forever begin
      m_tready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk);
      gap = pick_gap();
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  initial begin : main
    board = new();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    fork
      accept_results();
    join_none

    // identity matrix from reset: range ends, exactly one, just over one
    send_pixel(mk_pixel(0, 0, 0, 0, 0, 1'b1));
    send_pixel(mk_pixel(SAMPLE_POS_MAX, SAMPLE_NEG_MAX, 0, 255, 255, 1'b0));
    send_pixel(mk_pixel(SAMPLE_ONE, SAMPLE_ONE + 1, -1, 17, 200, 1'b0));
    send_pixel(mk_pixel(SAMPLE_NEG_MAX, SAMPLE_POS_MAX, SAMPLE_ONE, 128, 1, 1'b1));
    send_pixel(mk_pixel(1, -1, 65536, 255, 0, 1'b0));
    drain();

    // rounding ties and the coefficient extremes; the unused index is ignored
    write_row(REG_ROW_ONE, pack_row(1, 0, 0));
    write_row(REG_ROW_TWO, pack_row(COEF_POS_MAX, COEF_POS_MAX, COEF_POS_MAX));
    write_row(REG_ROW_THREE, pack_row(COEF_NEG_MAX, COEF_NEG_MAX, COEF_NEG_MAX));
    write_row(REG_UNUSED, random_row(1'b0));
    send_pixel(mk_pixel(512, 0, 0, 0, 255, 1'b1));
    send_pixel(mk_pixel(-512, 0, 0, 1, 1, 1'b0));
    send_pixel(mk_pixel(-513, 0, 0, 2, 3, 1'b0));
    send_pixel(mk_pixel(511, 0, 0, 4, 5, 1'b0));
    send_pixel(mk_pixel(1536, 1, -1, 6, 7, 1'b0));
    send_pixel(mk_pixel(-1536, 0, 0, 8, 9, 1'b0));
    send_pixel(mk_pixel(SAMPLE_NEG_MAX, SAMPLE_NEG_MAX, SAMPLE_NEG_MAX, 10, 11, 1'b0));
    send_pixel(mk_pixel(SAMPLE_POS_MAX, SAMPLE_POS_MAX, SAMPLE_POS_MAX, 12, 13, 1'b0));
    send_pixel(mk_pixel(SAMPLE_NEG_MAX, SAMPLE_POS_MAX, 0, 14, 15, 1'b1));
    send_pixel(mk_pixel(SAMPLE_ONE, SAMPLE_ONE, SAMPLE_ONE, 254, 254, 1'b0));
    drain();

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0: begin
          write_row(REG_ROW_ONE, '1);
          write_row(REG_ROW_TWO, '0);
          write_row(REG_ROW_THREE, '1);
        end
        1: begin
          write_row(REG_ROW_ONE, '0);
          write_row(REG_ROW_TWO, '1);
          write_row(REG_ROW_THREE, random_row(1'b1));
        end
        default: begin
          write_row(REG_ROW_ONE, random_row(ph % 2 == 0));
          write_row(REG_ROW_TWO, random_row(ph % 3 != 0));
          write_row(REG_ROW_THREE, random_row(ph != 4));
          if ($urandom_range(0, 1)) write_row(REG_UNUSED, random_row(1'b0));
        end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++)
        send_pixel(mk_pixel(random_sample(), random_sample(), random_sample(),
                            $urandom_range(0, 255), $urandom_range(0, 255),
                            $urandom_range(0, 24) == 0));
      drain();
    end

    if (board.fails == 0 && board.waiting() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
